// ===== design/fsge_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and default sizes of the falling sand grid engine.
package fsge_pkg;

    localparam int GRID_COLUMNS_DEF = 160;
    localparam int GRID_ROWS_DEF = 120;
    localparam int MAT_BITS = 2;
    localparam int CELL_DEPTH_DEF = ((GRID_ROWS_DEF + 1) / 2) * GRID_COLUMNS_DEF;

    typedef logic [MAT_BITS-1:0] mat_t;

    localparam mat_t MAT_EMPTY = 2'd0;
    localparam mat_t MAT_SAND = 2'd1;
    localparam mat_t MAT_WALL = 2'd2;
    localparam mat_t MAT_WATER = 2'd3;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_CLEAR,
        KIND_UPDATE
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        mat_t prev;
        mat_t here;
        mat_t next;
    } win_t;

    typedef struct packed {
        logic skip;
        logic first_prev;
    } rule_ctl_t;

endpackage

// ===== design/fsge_cmd_if.sv =====
`timescale 1ns / 1ps
// Command channel of the falling sand grid engine.
interface fsge_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [2:0] material;

    modport source (output valid, output kind, output x_coord, output y_coord,
                    output material, input ready);
    modport sink (input valid, input kind, input x_coord, input y_coord,
                  input material, output ready);
endinterface

// ===== design/fsge_res_if.sv =====
`timescale 1ns / 1ps
// Result channel of the falling sand grid engine.
interface fsge_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] read_material;
    logic       ignored;

    modport source (output valid, output read_material, output ignored, input ready);
    modport sink (input valid, input read_material, input ignored, output ready);
endinterface

// ===== design/fsge_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual port RAM with one write port and a registered read port.
module fsge_ram
    import fsge_pkg::*;
#(
    parameter int WIDTH = MAT_BITS,
    parameter int DEPTH = CELL_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fsge_rule.sv =====
`timescale 1ns / 1ps
// Movement rule for one cell, applied to a three cell window of two rows.
module fsge_rule
    import fsge_pkg::*;
(
    input  win_t      cur,
    input  win_t      low,
    input  rule_ctl_t ctl,
    output win_t      cur_new,
    output win_t      low_new,
    output logic      skip_next
);

    mat_t m;
    mat_t low_first;
    mat_t low_second;
    mat_t cur_first;
    mat_t cur_second;
    logic active;

    always_comb
    begin
        m = cur.here;
        active = !ctl.skip && (m == MAT_SAND || m == MAT_WATER);
        low_first = ctl.first_prev ? low.prev : low.next;
        low_second = ctl.first_prev ? low.next : low.prev;
        cur_first = ctl.first_prev ? cur.prev : cur.next;
        cur_second = ctl.first_prev ? cur.next : cur.prev;
        cur_new = cur;
        low_new = low;
        skip_next = 1'b0;
        if (active)
        begin
            if (low.here == MAT_EMPTY)
            begin
                low_new.here = m;
                cur_new.here = MAT_EMPTY;
            end
            else if (m == MAT_SAND && low.here == MAT_WATER)
            begin
                low_new.here = MAT_SAND;
                cur_new.here = MAT_WATER;
            end
            else if (low_first == MAT_EMPTY)
            begin
                cur_new.here = MAT_EMPTY;
                if (ctl.first_prev)
                begin
                    low_new.prev = m;
                end
                else
                begin
                    low_new.next = m;
                end
            end
            else if (low_second == MAT_EMPTY)
            begin
                cur_new.here = MAT_EMPTY;
                if (ctl.first_prev)
                begin
                    low_new.next = m;
                end
                else
                begin
                    low_new.prev = m;
                end
            end
            else if (m == MAT_WATER && cur_first == MAT_EMPTY)
            begin
                cur_new.here = MAT_EMPTY;
                skip_next = !ctl.first_prev;
                if (ctl.first_prev)
                begin
                    cur_new.prev = m;
                end
                else
                begin
                    cur_new.next = m;
                end
            end
            else if (m == MAT_WATER && cur_second == MAT_EMPTY)
            begin
                cur_new.here = MAT_EMPTY;
                skip_next = ctl.first_prev;
                if (ctl.first_prev)
                begin
                    cur_new.next = m;
                end
                else
                begin
                    cur_new.prev = m;
                end
            end
        end
    end

endmodule

// ===== design/falling_sand_grid_engine.sv =====
`timescale 1ns / 1ps
// Falling sand grid engine: grid storage, command sequencer and update scan.
//
// Commands arrive as words on cmd (kind, x_coord, y_coord, material) and each
// one gives exactly one result word on res (read_material, ignored).
// A write is answered without a memory read, a read after one memory read.
// A clear sweeps the grid memories one entry a cycle, ceil(GRID_ROWS/2) *
// GRID_COLUMNS entries each, 9600 for the default grid.
// An update scans rows from the second-to-last row upward, one cell a cycle.
// The cell rate is set by the two grid memories, even rows in one and odd
// rows in the other, each doing one read and one write a cycle for the
// current row and the row below.
// After reset the same clearing sweep runs and cmd.ready stays low until it
// ends; it gives no result.
// The result sits in an output register; a new command is taken while that
// register is empty or is being emptied in the same cycle. When the receiver
// stalls, the result holds and no further command is taken.
module falling_sand_grid_engine
    import fsge_pkg::*;
#(
    parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    fsge_cmd_if.sink   cmd,
    fsge_res_if.source res
);

    localparam int HALF_ROWS = (GRID_ROWS + 1) / 2;
    localparam int DEPTH = HALF_ROWS * GRID_COLUMNS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int T_LAST = GRID_COLUMNS + 3;
    localparam int TW = $clog2(GRID_COLUMNS + 4);
    localparam int ROW_START = GRID_ROWS - 2;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic clr_cmd_reg, clr_cmd_next;
    logic [TW-1:0] t_reg, t_next;
    logic [7:0] row_reg, row_next;
    logic parity_reg, parity_next;
    logic skip_reg, skip_next;
    win_t cur_win_reg, cur_win_next;
    win_t low_win_reg, low_win_next;
    logic rd_sel_reg, rd_sel_next;
    logic out_valid_reg, out_valid_next;
    mat_t out_mat_reg, out_mat_next;
    logic out_ign_reg, out_ign_next;

    logic accept;
    kind_t cmd_kind;
    logic in_grid;
    logic mat_ok;
    logic [7:0] addr_row;
    logic [AW-1:0] base;
    logic [AW-1:0] even_base;
    logic [AW-1:0] cmd_addr;
    logic ltr;
    logic [7:0] rcol, wcol, hcol;
    logic shift_live, wr_live, rd_live, t_end;
    mat_t cur_rd, low_rd, cur_in, low_in;
    win_t cur_new, low_new;
    logic rule_skip;
    rule_ctl_t rule_ctl;

    logic even_we, odd_we;
    logic [AW-1:0] even_waddr, odd_waddr, even_raddr, odd_raddr;
    mat_t even_wdata, odd_wdata, even_rdata, odd_rdata;

    function automatic logic [7:0] col_of(input logic [TW-1:0] k, input logic l2r);
        logic [7:0] k8;
        k8 = 8'(k);
        return l2r ? k8 : 8'(GRID_COLUMNS - 1) - k8;
    endfunction

    assign accept = cmd.valid && cmd.ready;
    assign cmd_kind = kind_t'(cmd.kind);
    assign in_grid = (9'(cmd.x_coord) < 9'(GRID_COLUMNS)) && (9'(cmd.y_coord) < 9'(GRID_ROWS));
    assign mat_ok = cmd.material <= 3'(MAT_WATER);
    assign addr_row = (state_reg == ST_UPDATE) ? row_reg : cmd.y_coord;
    assign base = AW'(int'(addr_row[7:1]) * GRID_COLUMNS);
    assign even_base = row_reg[0] ? base + AW'(GRID_COLUMNS) : base;
    assign cmd_addr = base + AW'(cmd.x_coord);

    assign ltr = parity_reg ^ row_reg[0];
    assign rcol = col_of(t_reg, ltr);
    assign wcol = col_of(t_reg - TW'(4), ltr);
    assign hcol = col_of(t_reg - TW'(3), ltr);
    assign shift_live = (t_reg != '0) && (t_reg <= TW'(GRID_COLUMNS));
    assign wr_live = (t_reg >= TW'(4)) && (t_reg <= TW'(T_LAST));
    assign rd_live = t_reg < TW'(GRID_COLUMNS);
    assign t_end = t_reg == TW'(T_LAST);

    assign cur_rd = row_reg[0] ? odd_rdata : even_rdata;
    assign low_rd = row_reg[0] ? even_rdata : odd_rdata;
    assign cur_in = shift_live ? cur_rd : MAT_WALL;
    assign low_in = shift_live ? low_rd : MAT_WALL;

    assign rule_ctl = '{skip: skip_reg, first_prev: !hcol[0]};

    fsge_rule u_rule (
        .cur       (cur_win_reg),
        .low       (low_win_reg),
        .ctl       (rule_ctl),
        .cur_new   (cur_new),
        .low_new   (low_new),
        .skip_next (rule_skip)
    );

    fsge_ram #(.WIDTH(MAT_BITS), .DEPTH(DEPTH)) u_ram_even (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    fsge_ram #(.WIDTH(MAT_BITS), .DEPTH(DEPTH)) u_ram_odd (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_kind)
                        KIND_READ:   state_next = in_grid ? ST_READ : ST_IDLE;
                        KIND_CLEAR:  state_next = ST_CLEAR;
                        KIND_UPDATE: state_next = ST_UPDATE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_UPDATE:
            begin
                if (t_end && row_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready = 1'b0;
        even_we = 1'b0;
        odd_we = 1'b0;
        even_waddr = cmd_addr;
        odd_waddr = cmd_addr;
        even_wdata = cmd.material[1:0];
        odd_wdata = cmd.material[1:0];
        even_raddr = cmd_addr;
        odd_raddr = cmd_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                even_we = 1'b1;
                odd_we = 1'b1;
                even_waddr = clr_reg;
                odd_waddr = clr_reg;
                even_wdata = MAT_EMPTY;
                odd_wdata = MAT_EMPTY;
            end
            ST_IDLE:
            begin
                cmd.ready = !out_valid_reg || res.ready;
                if (cmd.valid && cmd.ready && cmd_kind == KIND_WRITE && in_grid && mat_ok)
                begin
                    even_we = !cmd.y_coord[0];
                    odd_we = cmd.y_coord[0];
                end
            end
            ST_UPDATE:
            begin
                even_we = wr_live;
                odd_we = wr_live;
                even_waddr = even_base + AW'(wcol);
                odd_waddr = base + AW'(wcol);
                even_raddr = even_base + AW'(rcol);
                odd_raddr = base + AW'(rcol);
                even_wdata = row_reg[0] ? low_new.prev : cur_new.prev;
                odd_wdata = row_reg[0] ? cur_new.prev : low_new.prev;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_next = clr_reg;
        clr_cmd_next = clr_cmd_reg;
        t_next = t_reg;
        row_next = row_reg;
        parity_next = parity_reg;
        skip_next = skip_reg;
        cur_win_next = cur_win_reg;
        low_win_next = low_win_reg;
        rd_sel_next = rd_sel_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_mat_next = out_mat_reg;
        out_ign_next = out_ign_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    clr_next = '0;
                    clr_cmd_next = 1'b0;
                    if (clr_cmd_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_mat_next = MAT_EMPTY;
                        out_ign_next = 1'b0;
                    end
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_kind)
                        KIND_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            out_mat_next = MAT_EMPTY;
                            out_ign_next = !(in_grid && mat_ok);
                        end
                        KIND_READ:
                        begin
                            rd_sel_next = cmd.y_coord[0];
                            if (!in_grid)
                            begin
                                out_valid_next = 1'b1;
                                out_mat_next = MAT_EMPTY;
                                out_ign_next = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            clr_cmd_next = 1'b1;
                        end
                        KIND_UPDATE:
                        begin
                            parity_next = !parity_reg;
                            row_next = 8'(ROW_START);
                            t_next = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_mat_next = rd_sel_reg ? odd_rdata : even_rdata;
                out_ign_next = 1'b0;
            end
            ST_UPDATE:
            begin
                if (t_reg == '0)
                begin
                    cur_win_next = '{prev: MAT_WALL, here: MAT_WALL, next: MAT_WALL};
                    low_win_next = '{prev: MAT_WALL, here: MAT_WALL, next: MAT_WALL};
                    skip_next = 1'b0;
                end
                else
                begin
                    cur_win_next = '{prev: cur_new.here, here: cur_new.next, next: cur_in};
                    low_win_next = '{prev: low_new.here, here: low_new.next, next: low_in};
                    skip_next = rule_skip;
                end
                t_next = t_reg + TW'(1);
                if (t_end)
                begin
                    t_next = '0;
                    if (row_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_mat_next = MAT_EMPTY;
                        out_ign_next = 1'b0;
                    end
                    else
                    begin
                        row_next = row_reg - 8'd1;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            clr_cmd_reg <= 1'b0;
            t_reg <= '0;
            row_reg <= '0;
            parity_reg <= 1'b0;
            skip_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            clr_cmd_reg <= clr_cmd_next;
            t_reg <= t_next;
            row_reg <= row_next;
            parity_reg <= parity_next;
            skip_reg <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_win_reg <= cur_win_next;
        low_win_reg <= low_win_next;
        rd_sel_reg <= rd_sel_next;
        out_mat_reg <= out_mat_next;
        out_ign_reg <= out_ign_next;
    end

    assign res.valid = out_valid_reg;
    assign res.read_material = out_mat_reg;
    assign res.ignored = out_ign_reg;

    // During the scan the look-ahead read never hits the entry being written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && even_we && rd_live) |-> (even_waddr != even_raddr))
        else $error("scan write-back collides with look-ahead read");

    // A write command answers in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_kind == KIND_WRITE) |=> res.valid)
        else $error("write command gave no result");

    // Each update command flips the step parity exactly once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_kind == KIND_UPDATE) |=> (parity_reg != $past(parity_reg)))
        else $error("step parity did not flip on update");

endmodule

// ===== tb/sv/fsge_checker.sv =====
`timescale 1ns / 1ps
// Grid predictor and result checker for the falling sand grid engine.
module fsge_checker
    import fsge_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    fsge_cmd_if   cmd,
    fsge_res_if   res,
    output int    errors,
    output int    pending,
    output int    taken
);

    localparam int COLS = GRID_COLUMNS_DEF;
    localparam int ROWS = GRID_ROWS_DEF;

    typedef struct {
        mat_t read_material;
        logic ignored;
    } grid_answer_t;

    mat_t         grid_cells [ROWS][COLS];
    logic         moved_cells [ROWS][COLS];
    logic         scan_parity;
    grid_answer_t answer_queue [$];

    function automatic logic is_vacant(int col, int row);
        if (col < 0 || col >= COLS || row < 0 || row >= ROWS)
            return 1'b0;
        return grid_cells[row][col] == MAT_EMPTY;
    endfunction

    function automatic void shift_cell(int fc, int fr, int tc, int tr);
        grid_cells[tr][tc] = grid_cells[fr][fc];
        grid_cells[fr][fc] = MAT_EMPTY;
        moved_cells[tr][tc] = 1'b1;
    endfunction

    function automatic void settle_grid();
        int   row;
        int   pos;
        int   col;
        int   d1;
        int   d2;
        logic ltr;
        mat_t m;
        scan_parity = ~scan_parity;
        foreach (moved_cells[r, c])
            moved_cells[r][c] = 1'b0;
        for (row = ROWS - 2; row >= 0; row--)
        begin
            ltr = scan_parity ^ row[0];
            for (pos = 0; pos < COLS; pos++)
            begin
                col = ltr ? pos : COLS - 1 - pos;
                if (moved_cells[row][col])
                    continue;
                m = grid_cells[row][col];
                if (m == MAT_EMPTY || m == MAT_WALL)
                    continue;
                d1 = (scan_parity ^ col[0] ^ row[0]) ? -1 : 1;
                d2 = -d1;
                if (is_vacant(col, row + 1))
                begin
                    shift_cell(col, row, col, row + 1);
                    continue;
                end
                if (m == MAT_SAND && grid_cells[row + 1][col] == MAT_WATER)
                begin
                    grid_cells[row + 1][col] = MAT_SAND;
                    grid_cells[row][col] = MAT_WATER;
                    moved_cells[row + 1][col] = 1'b1;
                    moved_cells[row][col] = 1'b1;
                    continue;
                end
                if (is_vacant(col + d1, row + 1))
                begin
                    shift_cell(col, row, col + d1, row + 1);
                    continue;
                end
                if (is_vacant(col + d2, row + 1))
                begin
                    shift_cell(col, row, col + d2, row + 1);
                    continue;
                end
                if (m == MAT_WATER)
                begin
                    if (is_vacant(col + d1, row))
                        shift_cell(col, row, col + d1, row);
                    else if (is_vacant(col + d2, row))
                        shift_cell(col, row, col + d2, row);
                end
            end
        end
    endfunction

    function automatic grid_answer_t apply_command(kind_t k, logic [7:0] x, logic [7:0] y,
                                                   logic [2:0] mat);
        grid_answer_t a;
        logic         in_grid;
        a.read_material = MAT_EMPTY;
        a.ignored = 1'b0;
        in_grid = (x < COLS) && (y < ROWS);
        case (k)
            KIND_WRITE:
                if (in_grid && mat <= MAT_WATER)
                    grid_cells[y][x] = mat[1:0];
                else
                    a.ignored = 1'b1;
            KIND_READ:
                if (in_grid)
                    a.read_material = grid_cells[y][x];
                else
                    a.ignored = 1'b1;
            KIND_CLEAR:
                foreach (grid_cells[r, c])
                    grid_cells[r][c] = MAT_EMPTY;
            default:
                settle_grid();
        endcase
        return a;
    endfunction

    initial
    begin
        foreach (grid_cells[r, c])
        begin
            grid_cells[r][c] = MAT_EMPTY;
            moved_cells[r][c] = 1'b0;
        end
        scan_parity = 1'b0;
        errors = 0;
        pending = 0;
        taken = 0;
    end

    always @(posedge clk)
    begin
        grid_answer_t want;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                answer_queue.push_back(apply_command(kind_t'(cmd.kind), cmd.x_coord,
                                                     cmd.y_coord, cmd.material));
                taken++;
            end
            if (res.valid && res.ready)
            begin
                if (answer_queue.size() == 0)
                begin
                    $error("result word with no command pending");
                    errors++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (res.read_material !== want.read_material)
                    begin
                        $error("read_material: expected %0d, got %0d",
                               want.read_material, res.read_material);
                        errors++;
                    end
                    if (res.ignored !== want.ignored)
                    begin
                        $error("ignored: expected %0d, got %0d", want.ignored, res.ignored);
                        errors++;
                    end
                end
            end
            pending = answer_queue.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the falling sand grid engine testbench: stimulus, receiver and verdict.
module tb;
    import fsge_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   taken;
    int   sent;
    int   received;
    int   idle_cycles;
    logic bursty;

    fsge_cmd_if cmd ();
    fsge_res_if res ();

    falling_sand_grid_engine dut (.clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res));

    fsge_checker chk (.clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res), .errors(errors),
                      .pending(pending), .taken(taken));

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic issue(kind_t k, int x, int y, int mat);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.kind <= k;
        cmd.x_coord <= x[7:0];
        cmd.y_coord <= y[7:0];
        cmd.material <= mat[2:0];
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic random_item();
        int pick;
        int x;
        int y;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            x = $urandom_range(152, 159);
        else
            x = $urandom_range(0, 7);
        y = $urandom_range(110, 119);
        if (pick < 8)
            issue(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 7));
        else if (pick < 48)
            issue(KIND_WRITE, x, y, $urandom_range(0, 3));
        else if (pick < 78)
            issue(KIND_READ, x, y, $urandom_range(0, 7));
        else if (pick < 82)
            issue(KIND_READ, $urandom_range(0, 255), $urandom_range(0, 255), 0);
        else if (pick < 84)
            issue(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 7));
        else
            issue(KIND_UPDATE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 7));
    endtask

    initial
    begin
        int wait_cycles;
        cmd.valid = 1'b0;
        cmd.kind = KIND_WRITE;
        cmd.x_coord = '0;
        cmd.y_coord = '0;
        cmd.material = '0;
        sent = 0;
        bursty = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        issue(KIND_WRITE, 0, 0, MAT_SAND);
        issue(KIND_WRITE, 159, 119, MAT_WATER);
        issue(KIND_WRITE, 159, 0, MAT_WALL);
        issue(KIND_WRITE, 160, 5, MAT_SAND);
        issue(KIND_WRITE, 5, 120, MAT_SAND);
        issue(KIND_WRITE, 255, 255, MAT_WATER);
        issue(KIND_WRITE, 3, 3, 4);
        issue(KIND_WRITE, 3, 3, 7);
        issue(KIND_WRITE, 5, 119, MAT_WATER);
        issue(KIND_WRITE, 5, 118, MAT_SAND);
        issue(KIND_WRITE, 0, 119, MAT_SAND);
        issue(KIND_READ, 0, 0, 0);
        issue(KIND_READ, 159, 0, 0);
        issue(KIND_READ, 255, 255, 7);
        issue(KIND_UPDATE, 0, 0, 0);
        issue(KIND_READ, 0, 1, 0);
        issue(KIND_READ, 5, 119, 0);
        issue(KIND_READ, 5, 118, 0);
        issue(KIND_READ, 0, 119, 0);
        issue(KIND_READ, 159, 119, 0);
        issue(KIND_CLEAR, 0, 0, 0);
        issue(KIND_READ, 159, 0, 0);

        for (int i = 0; i < 100; i++)
        begin
            if (i % 20 == 0)
                bursty = $urandom_range(0, 1);
            random_item();
        end
        cmd.valid <= 1'b0;

        while (pending != 0 || taken != sent)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 50)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int  stall;
        logic held;
        res.ready = 1'b0;
        received = 0;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && received == 30)
            begin
                held = 1'b1;
                stall = 300;
            end
            else
                stall = bursty ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
            received++;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
        idle_cycles = 0;

endmodule
